// File: src/ips_pkg.sv
// Shared types and constants of the image plane scaler.
`default_nettype none
package ips_pkg;

  localparam int unsigned COORD_W   = 9;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned DIV_NW    = 18;
  localparam int unsigned DIV_DW    = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_NEAREST,
    CMD_BILIN
  } cmd_kind_e;

  typedef struct packed {
    logic [SIZE_W-1:0] sw;
    logic [SIZE_W-1:0] sh;
    logic [SIZE_W-1:0] dw;
    logic [SIZE_W-1:0] dh;
    logic              bilin;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [7:0]         x;
    logic [7:0]         y;
    logic [7:0]         pix;
    logic [COORD_W-1:0] c0;
    logic [COORD_W-1:0] c1;
    logic [COORD_W-1:0] r0;
    logic [COORD_W-1:0] r1;
    logic [SIZE_W-1:0]  fx;
    logic [SIZE_W-1:0]  fy;
  } cmd_t;

endpackage
`default_nettype wire

// File: src/ips_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module ips_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ips_pkg::DIV_NW-1:0] num_i,
  input  wire logic [ips_pkg::DIV_DW-1:0] den_i,
  output logic                            done_o,
  output logic [ips_pkg::DIV_NW-1:0]      quo_o,
  output logic [ips_pkg::DIV_DW-1:0]      rem_o
);

  localparam int unsigned NW = ips_pkg::DIV_NW;
  localparam int unsigned DW = ips_pkg::DIV_DW;
  localparam int unsigned CW = $clog2(NW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// File: src/ips_queue.sv
// Command queue between the front and the back of the scaler.
`default_nettype none
module ips_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ips_pkg::cmd_t push_data_i,
  input  wire logic          pop_i,
  output ips_pkg::cmd_t      pop_data_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned DEPTH = ips_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);

  ips_pkg::cmd_t slots_q [DEPTH];
  logic [PW-1:0] wptr_q;
  logic [PW-1:0] rptr_q;
  logic [PW:0]   cnt_q;

  assign full_o     = cnt_q == (PW+1)'(DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = slots_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// File: src/ips_front.sv
// Front end: accepts items and turns compute items into source coordinates and weights.
`default_nettype none
module ips_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ips_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          func_i,
  input  wire logic [7:0]    pos_x_i,
  input  wire logic [7:0]    pos_y_i,
  input  wire logic [7:0]    pixel_in_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output ips_pkg::cmd_t      q_data_o
);

  localparam int unsigned NW = ips_pkg::DIV_NW;
  localparam int unsigned DW = ips_pkg::DIV_DW;
  localparam int unsigned CW = ips_pkg::COORD_W;
  localparam int unsigned SW = ips_pkg::SIZE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_PUSH
  } state_e;

  state_e        state_q;
  ips_pkg::cmd_t cmd_q;
  ips_pkg::cmd_t wr_cmd;
  logic          accept;
  logic          in_store;
  logic [7:0]    mul_a;
  logic [SW-1:0] mul_b;
  logic [SW-1:0] mul_d;
  logic [NW-2:0] prod;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic [SW-1:0] lim;
  logic [CW-1:0] lo_c;
  logic [CW-1:0] hi_c;

  function automatic logic [CW-1:0] clip(input logic [NW-1:0] v, input logic [SW-1:0] size);
    logic [NW-1:0] top;
    top = NW'(size) - 1'b1;
    return (v > top) ? CW'(top) : CW'(v);
  endfunction

  assign in_ready_o = (state_q == ST_IDLE) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_store   = (int'(pos_x_i) < MAX_WIDTH) && (int'(pos_y_i) < MAX_HEIGHT);

  assign mul_a   = (state_q == ST_IDLE) ? pos_x_i : cmd_q.y;
  assign mul_b   = (state_q == ST_IDLE) ? cfg_i.sw : cfg_i.sh;
  assign mul_d   = (state_q == ST_IDLE) ? cfg_i.dw : cfg_i.dh;
  assign prod    = (NW-1)'((NW-1)'(mul_a) * (NW-1)'(mul_b));
  assign div_num = cfg_i.bilin ? {1'b0, prod} : ({prod, 1'b0} + NW'(mul_d));
  assign div_den = cfg_i.bilin ? {1'b0, mul_d} : {mul_d, 1'b0};

  assign div_start = (accept && func_i) || ((state_q == ST_DIVX) && div_done);

  assign lim  = (state_q == ST_DIVX) ? cfg_i.sw : cfg_i.sh;
  assign lo_c = clip(div_quo, lim);
  assign hi_c = cfg_i.bilin ? clip(div_quo + 1'b1, lim) : lo_c;

  always_comb begin
    wr_cmd      = '0;
    wr_cmd.kind = ips_pkg::CMD_WRITE;
    wr_cmd.pix  = pixel_in_i;
    wr_cmd.c0   = CW'(pos_x_i);
    wr_cmd.r0   = CW'(pos_y_i);
  end

  assign q_push_o = (accept && !func_i && in_store) || ((state_q == ST_PUSH) && !q_full_i);
  assign q_data_o = (state_q == ST_PUSH) ? cmd_q : wr_cmd;

  ips_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && func_i) begin
            state_q <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            state_q <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && func_i) begin
      cmd_q.kind <= cfg_i.bilin ? ips_pkg::CMD_BILIN : ips_pkg::CMD_NEAREST;
      cmd_q.x    <= pos_x_i;
      cmd_q.y    <= pos_y_i;
      cmd_q.pix  <= '0;
    end
    if ((state_q == ST_DIVX) && div_done) begin
      cmd_q.c0 <= lo_c;
      cmd_q.c1 <= hi_c;
      cmd_q.fx <= SW'(div_rem);
    end
    if ((state_q == ST_DIVY) && div_done) begin
      cmd_q.r0 <= lo_c;
      cmd_q.r1 <= hi_c;
      cmd_q.fy <= SW'(div_rem);
    end
  end

endmodule
`default_nettype wire

// File: src/ips_back.sv
// Back end: frame store, pixel fetch, interpolation and result register.
`default_nettype none
module ips_back #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ips_pkg::cfg_t cfg_i,
  input  wire logic          q_empty_i,
  input  wire ips_pkg::cmd_t q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_x_o,
  output logic [7:0]         out_y_o,
  output logic [7:0]         out_value_o
);

  localparam int unsigned NW    = ips_pkg::DIV_NW;
  localparam int unsigned DW    = ips_pkg::DIV_DW;
  localparam int unsigned SW    = ips_pkg::SIZE_W;
  localparam int unsigned CW    = ips_pkg::COORD_W;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RDA,
    ST_RDC,
    ST_MULT,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e        state_q;
  ips_pkg::cmd_t cmd_q;
  logic [1:0]    ridx_q;
  logic [1:0]    phase_q;
  logic [7:0]    pix_q [4];
  logic [7:0]    h0_q;
  logic [7:0]    val_q;
  logic [7:0]    rd_q;
  logic [7:0]    mem [DEPTH];
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [AW-1:0] addr;
  logic          mem_we;
  logic [7:0]    op_a;
  logic [7:0]    op_b;
  logic [SW-1:0] wt_b;
  logic [SW-1:0] size;
  logic [SW-1:0] wt_a;
  logic [NW-1:0] div_num;
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic          out_valid_q;
  logic [7:0]    out_x_q;
  logic [7:0]    out_y_q;
  logic [7:0]    out_value_q;

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;

  assign col    = (state_q == ST_RDA && ridx_q[0]) ? cmd_q.c1 : cmd_q.c0;
  assign row    = (state_q == ST_RDA && ridx_q[1]) ? cmd_q.r1 : cmd_q.r0;
  assign addr   = AW'(int'(row) * MAX_WIDTH + int'(col));
  assign mem_we = state_q == ST_WR;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= cmd_q.pix;
    end
    rd_q <= mem[addr];
  end

  always_comb begin
    case (phase_q)
      2'd0: begin
        op_a = pix_q[0];
        op_b = pix_q[1];
        wt_b = cmd_q.fx;
        size = cfg_i.dw;
      end
      2'd1: begin
        op_a = pix_q[2];
        op_b = pix_q[3];
        wt_b = cmd_q.fx;
        size = cfg_i.dw;
      end
      default: begin
        op_a = h0_q;
        op_b = div_quo[7:0];
        wt_b = cmd_q.fy;
        size = cfg_i.dh;
      end
    endcase
  end

  assign wt_a      = size - wt_b;
  assign div_num   = NW'(NW'(op_a) * NW'(wt_a)) + NW'(NW'(op_b) * NW'(wt_b));
  assign div_start = state_q == ST_MULT;

  ips_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (DW'(size)),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ridx_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            ridx_q  <= '0;
            phase_q <= '0;
            if (q_data_i.kind == ips_pkg::CMD_WRITE) begin
              state_q <= ST_WR;
            end else begin
              state_q <= ST_RDA;
            end
          end
        end
        ST_WR: state_q <= ST_IDLE;
        ST_RDA: state_q <= ST_RDC;
        ST_RDC: begin
          if (cmd_q.kind != ips_pkg::CMD_BILIN) begin
            state_q <= ST_OUT;
          end else if (ridx_q == 2'd3) begin
            state_q <= ST_MULT;
          end else begin
            ridx_q  <= ridx_q + 1'b1;
            state_q <= ST_RDA;
          end
        end
        ST_MULT: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            if (phase_q == 2'd2) begin
              state_q <= ST_OUT;
            end else begin
              phase_q <= phase_q + 1'b1;
              state_q <= ST_MULT;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_data_i;
    end
    if (state_q == ST_RDC) begin
      pix_q[ridx_q] <= rd_q;
      val_q         <= rd_q;
    end
    if (state_q == ST_DIV && div_done) begin
      if (phase_q == 2'd0) begin
        pix_q[0] <= div_quo[7:0];
      end
      if (phase_q == 2'd1) begin
        h0_q <= pix_q[0];
        pix_q[1] <= div_quo[7:0];
      end
      if (phase_q == 2'd2) begin
        val_q <= div_quo[7:0];
      end
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_x_q     <= cmd_q.x;
      out_y_q     <= cmd_q.y;
      out_value_q <= val_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_value_o = out_value_q;

endmodule
`default_nettype wire

// File: src/image_plane_scaler_top.sv
// Top level of the image plane scaler: configuration registers, front, queue and back.
//
//   channel   signals                                         direction
//   input     in_valid_i in_ready_o func_i pos_x_i pos_y_i pixel_in_i   in
//   result    out_valid_o out_ready_i out_x_o out_y_o out_value_o       out
//   config    cfg_we_i cfg_idx_i cfg_wdata_i                            in
//
// A write item is passed on by the front and stored in the frame store by the back.
// A compute item is worked out in the front by two 18-step divisions.
// A bilinear item then needs store reads of four source pixels on one port
// and three 18-step divisions in the back; a nearest item needs a single store read there.
// Reset clears all control state; the frame store holds no reset value.
// A four-entry queue and the result register let either side stall; the front is held once the queue is full.
`default_nettype none
module image_plane_scaler_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ips_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ips_pkg::SIZE_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            func_i,
  input  wire logic [7:0]                      pos_x_i,
  input  wire logic [7:0]                      pos_y_i,
  input  wire logic [7:0]                      pixel_in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [7:0]                           out_x_o,
  output logic [7:0]                           out_y_o,
  output logic [7:0]                           out_value_o
);

  localparam int unsigned SW = ips_pkg::SIZE_W;

  ips_pkg::cfg_t cfg_q;
  ips_pkg::cmd_t push_data;
  ips_pkg::cmd_t pop_data;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  logic [SW-1:0] nz;

  assign nz = (cfg_wdata_i == '0) ? SW'(1) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sw    <= (MAX_WIDTH < 256) ? SW'(MAX_WIDTH) : SW'(256);
      cfg_q.sh    <= (MAX_HEIGHT < 256) ? SW'(MAX_HEIGHT) : SW'(256);
      cfg_q.dw    <= SW'(256);
      cfg_q.dh    <= SW'(256);
      cfg_q.bilin <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ips_pkg::REG_SRC_W: cfg_q.sw <= (int'(nz) > MAX_WIDTH) ? SW'(MAX_WIDTH) : nz;
        ips_pkg::REG_SRC_H: cfg_q.sh <= (int'(nz) > MAX_HEIGHT) ? SW'(MAX_HEIGHT) : nz;
        ips_pkg::REG_DST_W: cfg_q.dw <= nz;
        ips_pkg::REG_DST_H: cfg_q.dh <= nz;
        ips_pkg::REG_MODE:  cfg_q.bilin <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  ips_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pixel_in_i (pixel_in_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  ips_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  ips_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (empty),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_value_o (out_value_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/image_plane_scaler_top_test.sv
// Testbench of the image plane scaler: directed and random pixel loads and scaling requests.
`default_nettype none
module image_plane_scaler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_W = 256;
  localparam int unsigned STORE_H = 256;
  localparam int unsigned SIZE_W = ips_pkg::SIZE_W;
  localparam int unsigned IDX_W = ips_pkg::CFG_IDX_W;
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;
  localparam int unsigned TAIL_CYCLES = 400;

  class pixel_scoreboard;
    logic [7:0] plane_mem [STORE_W*STORE_H];
    bit         written [STORE_W*STORE_H];
    int unsigned src_w, src_h, dst_w, dst_h;
    bit          bilin;
    logic [7:0]  pend_x[$], pend_y[$], pend_v[$];
    int unsigned errors, results, writes, computes;

    function new();
      src_w = 256; src_h = 256; dst_w = 256; dst_h = 256; bilin = 0;
      errors = 0; results = 0; writes = 0; computes = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      case (idx)
        ips_pkg::REG_SRC_W: src_w = clamp_size(val, STORE_W);
        ips_pkg::REG_SRC_H: src_h = clamp_size(val, STORE_H);
        ips_pkg::REG_DST_W: dst_w = clamp_size(val, 511);
        ips_pkg::REG_DST_H: dst_h = clamp_size(val, 511);
        ips_pkg::REG_MODE:  bilin = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pix_at(int unsigned x, int unsigned y);
      return plane_mem[y*STORE_W + x];
    endfunction

    // Source columns and rows that a compute at (x, y) reads in the current mode.
    function void source_span(int unsigned x, int unsigned y,
                              output int unsigned c0, output int unsigned c1,
                              output int unsigned r0, output int unsigned r1);
      int unsigned i, j;
      if (bilin) begin
        i = (x * src_w) / dst_w;
        j = (y * src_h) / dst_h;
        c0 = (i > src_w - 1) ? src_w - 1 : i;
        c1 = (i + 1 > src_w - 1) ? src_w - 1 : i + 1;
        r0 = (j > src_h - 1) ? src_h - 1 : j;
        r1 = (j + 1 > src_h - 1) ? src_h - 1 : j + 1;
      end else begin
        i = (2 * x * src_w + dst_w) / (2 * dst_w);
        j = (2 * y * src_h + dst_h) / (2 * dst_h);
        c0 = (i > src_w - 1) ? src_w - 1 : i;
        r0 = (j > src_h - 1) ? src_h - 1 : j;
        c1 = c0;
        r1 = r0;
      end
    endfunction

    function int unsigned row_blend(int unsigned x, int unsigned row);
      int unsigned prod, i, r, c0, c1;
      prod = x * src_w;
      i = prod / dst_w;
      r = prod % dst_w;
      c0 = (i > src_w - 1) ? src_w - 1 : i;
      c1 = (i + 1 > src_w - 1) ? src_w - 1 : i + 1;
      return ((pix_at(c0, row) * (dst_w - r) + pix_at(c1, row) * r) / dst_w) & 8'hFF;
    endfunction

    function int unsigned scaled_pixel(int unsigned x, int unsigned y);
      int unsigned prod, j, q, r0, r1, h0, h1, sx, sy;
      if (bilin) begin
        prod = y * src_h;
        j = prod / dst_h;
        q = prod % dst_h;
        r0 = (j > src_h - 1) ? src_h - 1 : j;
        r1 = (j + 1 > src_h - 1) ? src_h - 1 : j + 1;
        h0 = row_blend(x, r0);
        h1 = row_blend(x, r1);
        return ((h0 * (dst_h - q) + h1 * q) / dst_h) & 8'hFF;
      end
      sx = (2 * x * src_w + dst_w) / (2 * dst_w);
      sy = (2 * y * src_h + dst_h) / (2 * dst_h);
      if (sx > src_w - 1) sx = src_w - 1;
      if (sy > src_h - 1) sy = src_h - 1;
      return pix_at(sx, sy);
    endfunction

    function void note_input(logic f, logic [7:0] x, logic [7:0] y, logic [7:0] p);
      if (f == FUNC_WRITE) begin
        plane_mem[y*STORE_W + x] = p;
        written[y*STORE_W + x] = 1;
        writes++;
      end else begin
        pend_x.push_back(x);
        pend_y.push_back(y);
        pend_v.push_back(8'(scaled_pixel(x, y)));
        computes++;
      end
    endfunction

    function void check_result(logic [7:0] x, logic [7:0] y, logic [7:0] v);
      logic [7:0] ex, ey, ev;
      results++;
      if (pend_x.size() == 0) begin
        $error("unexpected result x=%0d y=%0d value=%0d", x, y, v);
        errors++;
        return;
      end
      ex = pend_x.pop_front();
      ey = pend_y.pop_front();
      ev = pend_v.pop_front();
      if (x !== ex) begin
        $error("out_x expected %0d actual %0d", ex, x);
        errors++;
      end
      if (y !== ey) begin
        $error("out_y expected %0d actual %0d", ey, y);
        errors++;
      end
      if (v !== ev) begin
        $error("out_value expected %0d actual %0d", ev, v);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = ips_pkg::REG_SRC_W;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i = FUNC_WRITE;
  logic [7:0] pos_x_i = '0;
  logic [7:0] pos_y_i = '0;
  logic [7:0] pixel_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] out_x_o, out_y_o, out_value_o;

  pixel_scoreboard sb = new();
  int unsigned sent = 0;

  always #5 clk_i = ~clk_i;

  image_plane_scaler_top uut (.*);

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result(out_x_o, out_y_o, out_value_o);
  end

  initial begin
    int unsigned g;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      g = gap_len();
      if (g == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic f, logic [7:0] x, logic [7:0] y, logic [7:0] p,
                           bit no_gap = 0);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    pos_x_i <= x;
    pos_y_i <= y;
    pixel_in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(f, x, y, p);
    sent++;
  endtask

  // Loads every source pixel that the compute will read before sending it.
  task automatic send_compute(logic [7:0] x, logic [7:0] y, logic [7:0] p);
    int unsigned c[2];
    int unsigned r[2];
    sb.source_span(x, y, c[0], c[1], r[0], r[1]);
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        if (!sb.written[r[a]*STORE_W + c[b]])
          send_item(FUNC_WRITE, 8'(c[b]), 8'(r[a]), 8'($urandom_range(0, 255)));
    send_item(FUNC_COMPUTE, x, y, p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pend_x.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_plane(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh, bit m);
    write_reg(ips_pkg::REG_SRC_W, SIZE_W'(sw));
    write_reg(ips_pkg::REG_SRC_H, SIZE_W'(sh));
    write_reg(ips_pkg::REG_DST_W, SIZE_W'(dw));
    write_reg(ips_pkg::REG_DST_H, SIZE_W'(dh));
    write_reg(ips_pkg::REG_MODE, SIZE_W'(m));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned k;
    int unsigned stop;
    stop = sent + n;
    while (sent < stop) begin
      k = $urandom_range(0, 99);
      if (k < 25)
        send_item(FUNC_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      else if (k < 85)
        send_compute(8'($urandom_range(0, sb.dst_w > 256 ? 255 : sb.dst_w - 1)),
                     8'($urandom_range(0, sb.dst_h > 256 ? 255 : sb.dst_h - 1)),
                     8'($urandom_range(0, 255)));
      else
        send_compute(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
    end
    drain();
  endtask

  initial begin
    int unsigned s;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_compute(8'd0, 8'd0, 8'd0);
    send_compute(8'd255, 8'd255, 8'hFF);
    send_item(FUNC_WRITE, 8'd255, 8'd0, 8'hFF);
    send_item(FUNC_WRITE, 8'd0, 8'd255, 8'h00);
    send_compute(8'd255, 8'd0, 8'h55);
    send_compute(8'd0, 8'd255, 8'hAA);
    drain();

    set_plane(1, 1, 256, 256, 1);
    send_compute(8'd0, 8'd0, 8'd0);
    send_compute(8'd255, 8'd255, 8'd0);
    drain();
    set_plane(0, 0, 0, 0, 0);
    send_compute(8'd7, 8'd9, 8'd0);
    drain();
    set_plane(511, 300, 1, 1, 1);
    send_compute(8'd0, 8'd0, 8'd0);
    send_compute(8'd200, 8'd100, 8'd0);
    drain();
    set_plane(256, 256, 511, 400, 1);
    send_compute(8'd255, 8'd255, 8'd0);
    send_compute(8'd128, 8'd3, 8'd0);
    drain();
    set_plane(20, 10, 8, 30, 0);
    send_item(FUNC_WRITE, 8'd100, 8'd200, 8'd77);
    send_compute(8'd7, 8'd29, 8'd0);
    send_compute(8'd250, 8'd250, 8'd0);
    drain();

    for (int p = 0; p < 10; p++) begin
      s = $urandom_range(0, 3);
      if (s == 0)
        set_plane($urandom_range(1, 256), $urandom_range(1, 256),
                  $urandom_range(1, 256), $urandom_range(1, 256), p[0]);
      else if (s == 1)
        set_plane($urandom_range(1, 16), $urandom_range(1, 16),
                  $urandom_range(1, 64), $urandom_range(1, 64), p[0]);
      else if (s == 2)
        set_plane($urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 511), $urandom_range(0, 511), p[0]);
      else
        set_plane($urandom_range(64, 256), $urandom_range(64, 256),
                  $urandom_range(1, 32), $urandom_range(1, 32), p[0]);
      random_phase(130);
    end

    $display("Sent %0d pixel writes and %0d scaling requests and checked %0d results.",
             sb.writes, sb.computes, sb.results);
    $display("Both modes ran over directed and random plane sizes, including zero and oversized.");
    if (sb.errors == 0 && sb.pend_x.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
